@@ sv/mfa_pkg.sv @@
// shared types and constants of the mixed fraction arithmetic unit
package mfa_pkg;

  localparam int unsigned IN_W    = 16;
  localparam int unsigned WHOLE_W = 63;
  localparam int unsigned NUM_W   = 49;
  localparam int unsigned DEN_W   = 48;
  localparam int unsigned FULL_W  = 64;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [IN_W-1:0] a_whole;
    logic [IN_W-1:0] a_num;
    logic [IN_W-1:0] a_den;
    logic [IN_W-1:0] b_whole;
    logic [IN_W-1:0] b_num;
    logic [IN_W-1:0] b_den;
    logic            zero_den;
  } entry_t;

endpackage

@@ sv/mixed_fraction_alu.sv @@
// top level of the mixed fraction arithmetic unit
//
//   channel  | handshake          | payload
//   operands | push / full        | cmd_i, a_whole_i, a_num_i, a_den_i, b_whole_i, b_num_i, b_den_i
//   results  | empty / pop        | res_whole_o, res_num_o, res_den_o, status_o
//
// one word at a time in the back end; with W = 4*OPERAND_BITS the work on a word
// is set by the binary gcd loop and the shared one-bit-per-cycle W-bit divider
// an operand word with a zero denominator goes from idle straight to the result write
// the two-entry queue keeps taking words while the back end works or a result waits
// reset (rst_ni low) empties the queue and the result register at once
module mixed_fraction_alu #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // operand side
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   cmd_i,
  input  logic [mfa_pkg::IN_W-1:0]     a_whole_i,
  input  logic [mfa_pkg::IN_W-1:0]     a_num_i,
  input  logic [mfa_pkg::IN_W-1:0]     a_den_i,
  input  logic [mfa_pkg::IN_W-1:0]     b_whole_i,
  input  logic [mfa_pkg::IN_W-1:0]     b_num_i,
  input  logic [mfa_pkg::IN_W-1:0]     b_den_i,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [mfa_pkg::WHOLE_W-1:0]  res_whole_o,
  output logic [mfa_pkg::NUM_W-1:0]    res_num_o,
  output logic [mfa_pkg::DEN_W-1:0]    res_den_o,
  output mfa_pkg::status_e             status_o
);
  import mfa_pkg::*;

  entry_t front_entry, q_entry;
  logic   q_empty, q_pop, res_valid;

  // operand trimming and zero denominator check
  mfa_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
    .cmd_i     (cmd_i),
    .a_whole_i (a_whole_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_whole_i (b_whole_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .entry_o   (front_entry)
  );

  // decoupling queue, full goes straight to the operand side
  mfa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_entry)
  );

  // sequenced arithmetic and result register
  mfa_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_entry),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_whole_o (res_whole_o),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .status_o    (status_o)
  );

  assign empty = !res_valid;

  // error results carry no fraction
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != STAT_OK) |-> (res_den_o == '0 && res_num_o == '0))
    else $error("error result with nonzero fields");

  // a good result always has a positive denominator
  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STAT_OK) |-> (res_den_o != '0))
    else $error("ok result with zero denominator");

  // whole part and remainder agree in sign
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STAT_OK && res_num_o != '0 && res_whole_o != '0)
      |-> (res_num_o[NUM_W-1] == res_whole_o[WHOLE_W-1]))
    else $error("sign mismatch between whole part and remainder");

endmodule

@@ sv/mfa_front.sv @@
// front end: trims operands to the operand width and flags zero denominators
module mfa_front #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic [1:0]              cmd_i,
  input  logic [mfa_pkg::IN_W-1:0] a_whole_i,
  input  logic [mfa_pkg::IN_W-1:0] a_num_i,
  input  logic [mfa_pkg::IN_W-1:0] a_den_i,
  input  logic [mfa_pkg::IN_W-1:0] b_whole_i,
  input  logic [mfa_pkg::IN_W-1:0] b_num_i,
  input  logic [mfa_pkg::IN_W-1:0] b_den_i,
  output mfa_pkg::entry_t          entry_o
);
  import mfa_pkg::*;

  always_comb begin
    entry_o = '0;
    entry_o.cmd = cmd_e'(cmd_i);
    for (int i = 0; i < IN_W; i++) begin
      if (i < OPERAND_BITS) begin
        entry_o.a_whole[i] = a_whole_i[i];
        entry_o.b_whole[i] = b_whole_i[i];
        entry_o.a_num[i]   = a_num_i[i];
        entry_o.a_den[i]   = a_den_i[i];
        entry_o.b_num[i]   = b_num_i[i];
        entry_o.b_den[i]   = b_den_i[i];
      end else begin
        // sign extension of the whole parts
        entry_o.a_whole[i] = a_whole_i[OPERAND_BITS-1];
        entry_o.b_whole[i] = b_whole_i[OPERAND_BITS-1];
      end
    end
    entry_o.zero_den = (entry_o.a_den == '0) || (entry_o.b_den == '0);
  end

endmodule

@@ sv/mfa_fifo.sv @@
// short queue between front and back
module mfa_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mfa_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mfa_pkg::entry_t rdata_o
);
  import mfa_pkg::*;

  entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, rptr_q;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/mfa_div.sv @@
// restoring divider, one quotient bit per cycle
module mfa_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quot_q, rem_q, dvs_q;
  logic [W:0]    rsh, diff;

  assign rsh    = {rem_q, quot_q[W-1]};
  assign diff   = rsh - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q  <= diff[W-1:0];
        quot_q <= {quot_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= rsh[W-1:0];
        quot_q <= {quot_q[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/mfa_back.sv @@
// back end: products, gcd, reductions and the result register
module mfa_back #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  mfa_pkg::entry_t              q_data_i,
  output logic                         q_pop_o,
  input  logic                         res_pop_i,
  output logic                         res_valid_o,
  output logic [mfa_pkg::WHOLE_W-1:0]  res_whole_o,
  output logic [mfa_pkg::NUM_W-1:0]    res_num_o,
  output logic [mfa_pkg::DEN_W-1:0]    res_den_o,
  output mfa_pkg::status_e             status_o
);
  import mfa_pkg::*;

  localparam int unsigned P  = OPERAND_BITS;
  localparam int unsigned MW = 2 * P + 2;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned W  = 4 * P;
  localparam int unsigned KW = $clog2(W + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_NA    = 12'b0000_0000_0010,
    S_NB    = 12'b0000_0000_0100,
    S_DEN   = 12'b0000_0000_1000,
    S_T1    = 12'b0000_0001_0000,
    S_T2    = 12'b0000_0010_0000,
    S_SIGN  = 12'b0000_0100_0000,
    S_GCD   = 12'b0000_1000_0000,
    S_DIVD  = 12'b0001_0000_0000,
    S_DIVN  = 12'b0010_0000_0000,
    S_DIVQ  = 12'b0100_0000_0000,
    S_WRITE = 12'b1000_0000_0000
  } state_e;

  state_e               st_q;
  cmd_e                 cmd_q;
  status_e              stat_q;
  logic signed [P-1:0]  aw_q, bw_q;
  logic [P-1:0]         an_q, ad_q, bn_q, bd_q;
  logic signed [MW-1:0] na_q, nb_q, ma, mb;
  logic signed [PW-1:0] prod, den_q, num_q, t1_q, num_abs, den_abs;
  logic                 neg_q;
  logic [W-1:0]         x_q, y_q, g_q, gcd_g, unum_q, uden_q, quo_q, rmd_q;
  logic [KW-1:0]        k_q;

  logic                 div_start, div_done;
  logic [W-1:0]         div_a, div_b, div_quot, div_rem;

  logic                 res_valid_q, res_load;
  logic [WHOLE_W-1:0]   res_whole_q;
  logic [NUM_W-1:0]     res_num_q;
  logic [DEN_W-1:0]     res_den_q;
  status_e              res_stat_q;
  logic [FULL_W-1:0]    q64, r64, d64;

  mfa_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_q)
      S_NA: begin
        ma = MW'(aw_q);
        mb = MW'(ad_q);
      end
      S_NB: begin
        ma = MW'(bw_q);
        mb = MW'(bd_q);
      end
      S_DEN: begin
        ma = MW'(ad_q);
        mb = (cmd_q == CMD_DIV) ? nb_q : MW'(bd_q);
      end
      S_T1: begin
        ma = na_q;
        mb = (cmd_q == CMD_MUL) ? nb_q : MW'(bd_q);
      end
      S_T2: begin
        ma = nb_q;
        mb = MW'(ad_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign num_abs = num_q[PW-1] ? -num_q : num_q;
  assign den_abs = den_q[PW-1] ? -den_q : den_q;
  assign gcd_g   = W'(y_q << k_q);
  assign q_pop_o = (st_q == S_IDLE) && !q_empty_i;
  assign res_load = (st_q == S_WRITE) && (!res_valid_q || res_pop_i);

  // divider start and operand select
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (st_q)
      S_GCD: begin
        div_start = (x_q == '0);
        div_a     = uden_q;
        div_b     = gcd_g;
      end
      S_DIVD: begin
        div_start = div_done;
        div_a     = unum_q;
        div_b     = g_q;
      end
      S_DIVN: begin
        div_start = div_done;
        div_a     = div_quot;
        div_b     = uden_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            st_q <= q_data_i.zero_den ? S_WRITE : S_NA;
          end
        end
        S_NA:   st_q <= S_NB;
        S_NB:   st_q <= S_DEN;
        S_DEN: begin
          if (cmd_q == CMD_DIV && nb_q == '0) begin
            st_q <= S_WRITE;
          end else begin
            st_q <= S_T1;
          end
        end
        S_T1:   st_q <= S_T2;
        S_T2:   st_q <= S_SIGN;
        S_SIGN: st_q <= S_GCD;
        S_GCD: begin
          if (x_q == '0) begin
            st_q <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            st_q <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            st_q <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            st_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (res_load) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cmd_q  <= q_data_i.cmd;
        aw_q   <= q_data_i.a_whole[P-1:0];
        an_q   <= q_data_i.a_num[P-1:0];
        ad_q   <= q_data_i.a_den[P-1:0];
        bw_q   <= q_data_i.b_whole[P-1:0];
        bn_q   <= q_data_i.b_num[P-1:0];
        bd_q   <= q_data_i.b_den[P-1:0];
        stat_q <= q_data_i.zero_den ? STAT_ZERO_DEN : STAT_OK;
      end
      S_NA: na_q <= MW'(prod + PW'(an_q));
      S_NB: nb_q <= MW'(prod + PW'(bn_q));
      S_DEN: begin
        den_q <= prod;
        if (cmd_q == CMD_DIV && nb_q == '0) begin
          stat_q <= STAT_DIV_ZERO;
        end
      end
      S_T1: t1_q <= prod;
      S_T2: begin
        case (cmd_q)
          CMD_ADD: num_q <= t1_q + prod;
          CMD_SUB: num_q <= t1_q - prod;
          default: num_q <= t1_q;
        endcase
      end
      S_SIGN: begin
        // negative divisor moves its sign into the numerator
        neg_q  <= num_q[PW-1] ^ den_q[PW-1];
        x_q    <= W'(num_abs);
        y_q    <= W'(den_abs);
        unum_q <= W'(num_abs);
        uden_q <= W'(den_abs);
        k_q    <= '0;
      end
      S_GCD: begin
        if (x_q == '0) begin
          g_q <= gcd_g;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          uden_q <= div_quot;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          unum_q <= div_quot;
        end
      end
      S_DIVQ: begin
        if (div_done) begin
          quo_q <= div_quot;
          rmd_q <= div_rem;
        end
      end
      default: begin
      end
    endcase
  end

  // sign applied at full width, then cut to the field widths
  always_comb begin
    q64 = FULL_W'(quo_q);
    r64 = FULL_W'(rmd_q);
    d64 = FULL_W'(uden_q);
    if (neg_q) begin
      q64 = -q64;
      r64 = -r64;
    end
    if (stat_q != STAT_OK) begin
      q64 = '0;
      r64 = '0;
      d64 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_whole_q <= q64[WHOLE_W-1:0];
      res_num_q   <= r64[NUM_W-1:0];
      res_den_q   <= d64[DEN_W-1:0];
      res_stat_q  <= stat_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_whole_o = res_whole_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign status_o    = res_stat_q;

endmodule

@@ verif/mixed_fraction_alu_tb.sv @@
// self-checking testbench of the mixed fraction arithmetic unit
module mixed_fraction_alu_tb;
  import mfa_pkg::*;

  // a generous bound on a run of some 550 words, stalls included
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    status_e            st;
  } fraction_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [1:0]          cmd_i;
  logic [IN_W-1:0]     a_whole_i, a_num_i, a_den_i;
  logic [IN_W-1:0]     b_whole_i, b_num_i, b_den_i;
  logic                empty;
  logic                pop;
  logic [WHOLE_W-1:0]  res_whole_o;
  logic [NUM_W-1:0]    res_num_o;
  logic [DEN_W-1:0]    res_den_o;
  status_e             status_o;

  fraction_t   pending_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned hold_left;
  bit          steady;   // no random idling on either side while set

  mixed_fraction_alu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .a_whole_i   (a_whole_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_whole_i   (b_whole_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .empty       (empty),
    .pop         (pop),
    .res_whole_o (res_whole_o),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // exact rational result: improper fractions, gcd reduction, split toward zero
  function automatic fraction_t fraction_result(cmd_e c, logic [IN_W-1:0] aw, an, ad,
                                                logic [IN_W-1:0] bw, bn, bd);
    longint          na, nb, num, den;
    longint unsigned un, ud, g, h, t, q, r;
    bit              neg;
    fraction_t       res;
    res = '0;
    res.st = STAT_OK;
    if (ad == 0 || bd == 0) begin
      res.st = STAT_ZERO_DEN;
      return res;
    end
    na = longint'($signed(aw)) * longint'(ad) + longint'(an);
    nb = longint'($signed(bw)) * longint'(bd) + longint'(bn);
    den = longint'(ad) * longint'(bd);
    case (c)
      CMD_ADD: num = na * longint'(bd) + nb * longint'(ad);
      CMD_SUB: num = na * longint'(bd) - nb * longint'(ad);
      CMD_MUL: num = na * nb;
      default: begin
        if (nb == 0) begin
          res.st = STAT_DIV_ZERO;
          return res;
        end
        num = na * longint'(bd);
        den = longint'(ad) * nb;
        // divisor sign moves into the numerator
        if (den < 0) begin
          den = -den;
          num = -num;
        end
      end
    endcase
    neg = num < 0;
    un = neg ? longint'(-num) : num;
    ud = den;
    g = un;
    h = ud;
    while (h != 0) begin
      t = g % h;
      g = h;
      h = t;
    end
    un = un / g;
    ud = ud / g;
    q = un / ud;
    r = un % ud;
    if (neg) begin
      q = -q;
      r = -r;
    end
    res.whole = q[WHOLE_W-1:0];
    res.num   = r[NUM_W-1:0];
    res.den   = ud[DEN_W-1:0];
    return res;
  endfunction

  // result side: random pop, long hold-off on request, check at the falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= steady || ($urandom_range(99) >= 17);
    end
  end

  always @(negedge clk_i) begin
    fraction_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: whole %0d num %0d den %0d status %0d",
                   $signed(res_whole_o), $signed(res_num_o), res_den_o, status_o);
      end else begin
        want = pending_q.pop_front();
        if (res_whole_o !== want.whole || res_num_o !== want.num ||
            res_den_o !== want.den || status_o !== want.st) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected %0d %0d/%0d st %0d, got %0d %0d/%0d st %0d",
                     $signed(want.whole), $signed(want.num), want.den, want.st,
                     $signed(res_whole_o), $signed(res_num_o), res_den_o, status_o);
        end
      end
    end
  end

  // offer one operand word and wait until it is taken
  task automatic send_word(cmd_e c, logic [IN_W-1:0] aw, an, ad, bw, bn, bd);
    bit taken;
    while (!steady && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    cmd_i     <= c;
    a_whole_i <= aw;
    a_num_i   <= an;
    a_den_i   <= ad;
    b_whole_i <= bw;
    b_num_i   <= bn;
    b_den_i   <= bd;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end
    pending_q.push_back(fraction_result(c, aw, an, ad, bw, bn, bd));
  endtask

  // stop offering, then wait for every outstanding result
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // random word: mostly well-formed operands, some zero denominators and zero divisors
  task automatic send_random_word();
    cmd_e            c;
    logic [IN_W-1:0] aw, an, ad, bw, bn, bd;
    c  = cmd_e'($urandom_range(3));
    aw = IN_W'($urandom_range(65535));
    an = IN_W'($urandom_range(65535));
    ad = IN_W'($urandom_range(1, 65535));
    bw = IN_W'($urandom_range(65535));
    bn = IN_W'($urandom_range(65535));
    bd = IN_W'($urandom_range(1, 65535));
    case ($urandom_range(19))
      0: ad = '0;
      1: bd = '0;
      2: begin
        bw = '0;
        bn = '0;
      end
      3: begin
        // small operands give small reduced results
        aw = IN_W'($urandom_range(7) - 4);
        an = IN_W'($urandom_range(9));
        ad = IN_W'($urandom_range(1, 9));
        bw = IN_W'($urandom_range(7) - 4);
        bn = IN_W'($urandom_range(9));
        bd = IN_W'($urandom_range(1, 9));
      end
      default: ;
    endcase
    send_word(c, aw, an, ad, bw, bn, bd);
  endtask

  task automatic test_directed();
    send_word(CMD_ADD, 16'd1, 16'd1, 16'd2, 16'd2, 16'd1, 16'd3);
    send_word(CMD_SUB, 16'd1, 16'd1, 16'd2, 16'd3, 16'd1, 16'd4);
    send_word(CMD_MUL, 16'hfffe, 16'd1, 16'd3, 16'd4, 16'd2, 16'd5);
    send_word(CMD_DIV, 16'd5, 16'd1, 16'd2, 16'd2, 16'd1, 16'd4);
    // zero denominator on either side, and ahead of a zero divisor
    send_word(CMD_ADD, 16'd3, 16'd1, 16'd0, 16'd1, 16'd1, 16'd2);
    send_word(CMD_MUL, 16'd3, 16'd1, 16'd2, 16'd1, 16'd1, 16'd0);
    send_word(CMD_DIV, 16'd3, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    // division by a zero value, also as -1 + 7/7
    send_word(CMD_DIV, 16'd7, 16'd1, 16'd2, 16'd0, 16'd0, 16'd9);
    send_word(CMD_DIV, 16'd7, 16'd1, 16'd2, 16'hffff, 16'd7, 16'd7);
    // zero result
    send_word(CMD_SUB, 16'd2, 16'd1, 16'd3, 16'd2, 16'd2, 16'd6);
    send_word(CMD_MUL, 16'd0, 16'd0, 16'd5, 16'd9, 16'd1, 16'd2);
    // negative divisor
    send_word(CMD_DIV, 16'd3, 16'd1, 16'd4, 16'hfffd, 16'd1, 16'd2);
    // improper operand fractions
    send_word(CMD_ADD, 16'd1, 16'd9, 16'd4, 16'd0, 16'd65535, 16'd2);
    // extremes of the operand fields
    send_word(CMD_MUL, 16'h8000, 16'hffff, 16'hffff, 16'h8000, 16'hffff, 16'hffff);
    send_word(CMD_MUL, 16'h7fff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff, 16'hffff);
    send_word(CMD_ADD, 16'h8000, 16'd0, 16'hffff, 16'h8000, 16'd0, 16'hfffe);
    send_word(CMD_SUB, 16'h7fff, 16'hfffe, 16'hffff, 16'h8000, 16'd1, 16'hfffd);
    send_word(CMD_DIV, 16'h8000, 16'd0, 16'd1, 16'd0, 16'd1, 16'hffff);
    send_word(CMD_DIV, 16'h7fff, 16'hffff, 16'hffff, 16'h8000, 16'd1, 16'hffff);
    send_word(CMD_DIV, 16'd0, 16'd1, 16'hffff, 16'h7fff, 16'hffff, 16'hffff);
    send_word(CMD_SUB, 16'h8000, 16'd0, 16'd1, 16'h7fff, 16'd0, 16'd1);
  endtask

  // results held back long enough for the queue to fill and push to stall
  task automatic test_backpressure();
    hold_left <= 4000;
    repeat (8) send_random_word();
  endtask

  // sender waits for every outstanding result before going on
  task automatic test_pause();
    repeat (4) send_random_word();
    wait_drained();
    repeat (4) send_random_word();
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      // one long stretch with no idling on either side
      steady = (i >= n / 3) && (i < n / 3 + 60);
      send_random_word();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    push       = 1'b0;
    cmd_i      = CMD_ADD;
    a_whole_i  = '0;
    a_num_i    = '0;
    a_den_i    = '0;
    b_whole_i  = '0;
    b_num_i    = '0;
    b_den_i    = '0;
    mismatches = 0;
    steady     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_pause();
    test_random(510);
    push <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
